FILE: hdl/rfae_pkg.sv
// Package for the register-file ALU execute block.
// Field widths, the operation codes and the default register count.
// No dependencies.
package rfae_pkg;

  localparam int unsigned NumRegsDef = 32;
  localparam int unsigned FuncW      = 3;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned WordW      = 32;

  typedef logic [WordW-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_AND = 3'd4,
    FUNC_OR  = 3'd5,
    FUNC_XOR = 3'd6,
    FUNC_LDI = 3'd7
  } func_e;

endpackage

FILE: hdl/rfae_if.sv
// Valid/ready channel interfaces: instruction in, result out.
// Depends on rfae_pkg for field widths.
interface rfae_instr_if;
  logic                                  valid;
  logic                                  ready;
  logic        [rfae_pkg::FuncW-1:0]     func;
  logic        [rfae_pkg::IdxW-1:0]      dest_reg;
  logic        [rfae_pkg::IdxW-1:0]      src_a_reg;
  logic        [rfae_pkg::IdxW-1:0]      src_b_reg;
  logic signed [rfae_pkg::WordW-1:0]     immediate;

  modport source (output valid, func, dest_reg, src_a_reg, src_b_reg, immediate,
                  input ready);
  modport sink   (input valid, func, dest_reg, src_a_reg, src_b_reg, immediate,
                  output ready);
endinterface

interface rfae_result_if;
  logic                                  valid;
  logic                                  ready;
  logic        [rfae_pkg::IdxW-1:0]      written_reg;
  logic signed [rfae_pkg::WordW-1:0]     result_value;
  logic                                  divide_error;

  modport source (output valid, written_reg, result_value, divide_error,
                  input ready);
  modport sink   (input valid, written_reg, result_value, divide_error,
                  output ready);
endinterface

FILE: hdl/rfae_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module rfae_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/rfae_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on rfae_pkg. Divisor must be nonzero when started.
module rfae_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  rfae_pkg::word_t dividend_i,
  input  rfae_pkg::word_t divisor_i,
  output logic            done_o,
  output rfae_pkg::word_t quot_o
);
  import rfae_pkg::*;

  localparam int unsigned CntW = $clog2(WordW);

  logic            busy_q, fin_q, done_q;
  logic [CntW-1:0] cnt_q;
  word_t           rem_q;
  word_t           quo_q, dvs_q, quot_q;
  logic            neg_q;

  logic [WordW:0]  rem_sh, diff;

  assign rem_sh = {rem_q, quo_q[WordW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(WordW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // datapath: restoring division on magnitudes; remainder stays below the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[WordW-1] ? (~dividend_i + 1'b1) : dividend_i;
      dvs_q <= divisor_i[WordW-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_q <= dividend_i[WordW-1] ^ divisor_i[WordW-1];
    end else if (busy_q) begin
      if (!diff[WordW]) begin
        rem_q <= diff[WordW-1:0];
        quo_q <= {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[WordW-1:0];
        quo_q <= {quo_q[WordW-2:0], 1'b0};
      end
    end
    if (fin_q) begin
      quot_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: hdl/register_file_alu_execute.sv
// Top level of the register-file ALU execute block.
// Depends on rfae_pkg, rfae_if (channel interfaces), rfae_ram and rfae_div.
//
//   channel    dir   modport  payload
//   instr_i    in    sink     func, dest_reg, src_a_reg, src_b_reg, immediate
//   result_o   out   source   written_reg, result_value, divide_error
//
// One instruction in flight at a time. A non-divide transaction goes through RAM read,
// operand latch, execute and write, and the next one is taken once the sequencer is
// back in idle; a divide waits in its own state between execute and write until the
// divider reports done.
// Reset clears the per-register valid bits, so every register reads zero
// without a clearing pass. A result held on result_o does not block the next
// instruction; only its own write-back waits for the result register to free.
module register_file_alu_execute #(
  parameter int unsigned NUM_REGS = rfae_pkg::NumRegsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rfae_instr_if.sink    instr_i,
  rfae_result_if.source result_o
);
  import rfae_pkg::*;

  localparam int unsigned AddrW = $clog2(NUM_REGS);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [NUM_REGS-1:0] vld_q;

  // latched instruction
  func_e       func_q;
  idx_t        dest_q;
  word_t       imm_q;
  logic        dest_ok_q, a_ok_q, b_ok_q;
  word_t       a_q, b_q;
  word_t       res_q;
  logic        err_q;

  // output register
  logic        out_vld_q;
  idx_t        out_reg_q;
  word_t       out_val_q;
  logic        out_err_q;

  logic        accept, wb_go, ram_we, div_start, div_done;
  logic        a_in_rng, b_in_rng, d_in_rng;
  logic [AddrW-1:0] a_addr, b_addr, wr_addr;
  word_t       rd_a, rd_b, quot, alu_res;

  assign accept = instr_i.valid && instr_i.ready;
  assign instr_i.ready = (state_q == ST_IDLE);

  // indices at or above NUM_REGS read zero and are never written
  assign a_in_rng = (32'(instr_i.src_a_reg) < NUM_REGS);
  assign b_in_rng = (32'(instr_i.src_b_reg) < NUM_REGS);
  assign d_in_rng = (32'(instr_i.dest_reg)  < NUM_REGS);
  assign a_addr   = AddrW'(instr_i.src_a_reg);
  assign b_addr   = AddrW'(instr_i.src_b_reg);
  assign wr_addr  = AddrW'(dest_q);

  // write-back waits only for the result register to be free
  assign wb_go  = (state_q == ST_DONE) && (!out_vld_q || result_o.ready);
  assign ram_we = wb_go && !err_q && dest_ok_q;

  // two copies of the register file give both source reads in one cycle
  rfae_ram #(.WIDTH(WordW), .DEPTH(NUM_REGS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (res_q),
    .re_i    (accept),
    .raddr_i (a_addr),
    .rdata_o (rd_a)
  );

  rfae_ram #(.WIDTH(WordW), .DEPTH(NUM_REGS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (res_q),
    .re_i    (accept),
    .raddr_i (b_addr),
    .rdata_o (rd_b)
  );

  assign div_start = (state_q == ST_EXEC) && (func_q == FUNC_DIV) && (b_q != '0);

  rfae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // single-cycle operations; product keeps its low word
  always_comb begin
    case (func_q)
      FUNC_ADD: alu_res = a_q + b_q;
      FUNC_SUB: alu_res = a_q - b_q;
      FUNC_MUL: alu_res = a_q * b_q;
      FUNC_AND: alu_res = a_q & b_q;
      FUNC_OR:  alu_res = a_q | b_q;
      FUNC_XOR: alu_res = a_q ^ b_q;
      FUNC_LDI: alu_res = imm_q;
      default:  alu_res = '0;   // divide with zero divisor
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = div_start ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (wb_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (wb_go) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q    <= func_e'(instr_i.func);
      dest_q    <= instr_i.dest_reg;
      imm_q     <= instr_i.immediate;
      dest_ok_q <= d_in_rng;
      // valid bit sampled alongside the RAM read; unwritten entries read zero
      a_ok_q    <= a_in_rng && vld_q[a_addr];
      b_ok_q    <= b_in_rng && vld_q[b_addr];
    end
    if (state_q == ST_READ) begin
      a_q <= a_ok_q ? rd_a : '0;
      b_q <= b_ok_q ? rd_b : '0;
    end
    if (state_q == ST_EXEC) begin
      res_q <= alu_res;
      err_q <= (func_q == FUNC_DIV) && (b_q == '0);
    end
    if ((state_q == ST_DIV) && div_done) begin
      res_q <= quot;
    end
    if (wb_go) begin
      out_reg_q <= dest_q;
      out_val_q <= res_q;
      out_err_q <= err_q;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.written_reg  = out_reg_q;
  assign result_o.result_value = out_val_q;
  assign result_o.divide_error = out_err_q;

endmodule

FILE: test/tb.sv
// Self-checking testbench for register_file_alu_execute.
// Needs rfae_pkg, the rfae_instr_if / rfae_result_if interfaces and the block itself.
// Instructions are predicted against a model register file; every result is checked in order.
`timescale 1ns / 100ps

module tb;

  import rfae_pkg::*;

  localparam int unsigned NumRegs       = NumRegsDef;
  // Longest quiet spell in a correct run comes from a long sender gap, a divide
  // and a long result stall.
  localparam int unsigned WatchdogLimit = 4000;
  // After the last result, keep clocking for longer than a divide takes to show
  // its result.
  localparam int unsigned DrainCycles   = 60;

  typedef struct packed {
    func_e func;
    idx_t  dest;
    idx_t  src_a;
    idx_t  src_b;
    word_t imm;
  } instr_t;

  typedef struct packed {
    idx_t  reg_idx;
    word_t value;
    logic  div_err;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rfae_instr_if  instr_bus ();
  rfae_result_if result_bus ();

  register_file_alu_execute #(
    .NUM_REGS(NumRegs)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .instr_i (instr_bus),
    .result_o(result_bus)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model of the architectural register file and the in-order result queue
  word_t   reg_model [NumRegs];
  result_t pending_results [$];
  idx_t    last_dest = '0;
  bit      calm      = 1'b0;  // set: no gaps on either side
  int      errors    = 0;

  // ---------------------------------------------------------------------------
  // Predictor: executes one instruction on the model and returns its result.
  // Sources are read before the write, so src == dest sees the old value.
  // ---------------------------------------------------------------------------
  function automatic result_t execute_model(instr_t it);
    result_t res;
    word_t   op_a;
    word_t   op_b;
    word_t   mag_a;
    word_t   mag_b;
    word_t   quot;
    op_a = (it.src_a < NumRegs) ? reg_model[it.src_a] : '0;
    op_b = (it.src_b < NumRegs) ? reg_model[it.src_b] : '0;
    res.reg_idx = it.dest;
    res.value   = '0;
    res.div_err = 1'b0;
    case (it.func)
      FUNC_ADD: res.value = op_a + op_b;
      FUNC_SUB: res.value = op_a - op_b;
      FUNC_MUL: res.value = op_a * op_b;      // low 32 bits of the product
      FUNC_DIV: begin
        if (op_b == '0) begin
          res.div_err = 1'b1;                 // value stays zero, no write
        end else begin
          // magnitudes, unsigned quotient, then sign: truncates toward zero
          // and lets most-negative / -1 wrap back to most-negative
          mag_a = op_a[WordW-1] ? -op_a : op_a;
          mag_b = op_b[WordW-1] ? -op_b : op_b;
          quot  = mag_a / mag_b;
          res.value = (op_a[WordW-1] ^ op_b[WordW-1]) ? -quot : quot;
        end
      end
      FUNC_AND: res.value = op_a & op_b;
      FUNC_OR:  res.value = op_a | op_b;
      FUNC_XOR: res.value = op_a ^ op_b;
      default:  res.value = it.imm;           // load immediate
    endcase
    if (!res.div_err && it.dest < NumRegs) begin
      reg_model[it.dest] = res.value;
    end
    return res;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Operand values biased toward the interesting corners
  function automatic word_t random_word();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 32)) - word_t'(16);
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0001;
          default: return '0;
        endcase
      end
      2: return word_t'(1) << $urandom_range(0, 31);
      default: return word_t'($urandom());
    endcase
  endfunction

  // Random instruction; some sources pick up the previous destination so
  // back-to-back dependencies through the register file get exercised.
  function automatic instr_t random_instr();
    instr_t      it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.func = FUNC_LDI;
    end else if (pick < 40) begin
      it.func = FUNC_DIV;
    end else begin
      it.func = func_e'($urandom_range(0, 6));
    end
    it.dest  = idx_t'($urandom_range(0, 31));
    it.src_a = ($urandom_range(0, 9) < 3) ? last_dest : idx_t'($urandom_range(0, 31));
    it.src_b = ($urandom_range(0, 9) < 2) ? last_dest : idx_t'($urandom_range(0, 31));
    it.imm   = random_word();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Instruction driver. valid stays high after a transaction so the next one
  // can follow without a bubble; it is only lowered when a gap starts or in
  // release_instr, never in the same step as it is raised.
  // ---------------------------------------------------------------------------
  task automatic send_instr(instr_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      instr_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_bus.valid     <= 1'b1;
    instr_bus.func      <= it.func;
    instr_bus.dest_reg  <= it.dest;
    instr_bus.src_a_reg <= it.src_a;
    instr_bus.src_b_reg <= it.src_b;
    instr_bus.immediate <= it.imm;
    do @(posedge clk_i); while (!instr_bus.ready);
    pending_results.push_back(execute_model(it));
    last_dest = it.dest;
  endtask

  task automatic send_op(func_e f, idx_t d, idx_t a, idx_t b, word_t imm);
    instr_t it;
    it.func  = f;
    it.dest  = d;
    it.src_a = a;
    it.src_b = b;
    it.imm   = imm;
    send_instr(it);
  endtask

  // Drop valid and move one step on, so a later send never raises it in the same step
  task automatic release_instr();
    instr_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    release_instr();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test cases
  // ---------------------------------------------------------------------------

  // Corner cases of every operation
  task automatic test_directed_cases();
    send_op(FUNC_LDI, 5'd1,  5'd0, 5'd0, 32'h7fff_ffff);
    send_op(FUNC_LDI, 5'd2,  5'd0, 5'd0, 32'h0000_0001);
    send_op(FUNC_LDI, 5'd3,  5'd0, 5'd0, 32'h8000_0000);
    send_op(FUNC_LDI, 5'd4,  5'd0, 5'd0, 32'hffff_ffff);
    send_op(FUNC_LDI, 5'd31, 5'd0, 5'd0, 32'h5a5a_a5a5);
    send_op(FUNC_LDI, 5'd0,  5'd0, 5'd0, 32'h0000_0000);
    // wrap-around on add, sub and mul
    send_op(FUNC_ADD, 5'd5,  5'd1, 5'd2, 32'hffff_ffff);
    send_op(FUNC_SUB, 5'd6,  5'd3, 5'd2, 32'h0);
    send_op(FUNC_MUL, 5'd7,  5'd1, 5'd1, 32'h0);
    send_op(FUNC_MUL, 5'd8,  5'd3, 5'd4, 32'h0);
    // most negative over minus one
    send_op(FUNC_DIV, 5'd9,  5'd3, 5'd4, 32'h0);
    // zero divisor from a register never written, then read the untouched dest
    send_op(FUNC_DIV, 5'd10, 5'd1, 5'd30, 32'h0);
    send_op(FUNC_OR,  5'd11, 5'd10, 5'd10, 32'h0);
    // truncation toward zero and negative divisors
    send_op(FUNC_LDI, 5'd12, 5'd0, 5'd0, 32'hffff_fff9);
    send_op(FUNC_LDI, 5'd13, 5'd0, 5'd0, 32'h0000_0002);
    send_op(FUNC_LDI, 5'd14, 5'd0, 5'd0, 32'hffff_fffe);
    send_op(FUNC_DIV, 5'd15, 5'd12, 5'd13, 32'h0);
    send_op(FUNC_DIV, 5'd16, 5'd1,  5'd14, 32'h0);
    send_op(FUNC_DIV, 5'd17, 5'd12, 5'd14, 32'h0);
    // logic operations
    send_op(FUNC_AND, 5'd18, 5'd31, 5'd4, 32'h0);
    send_op(FUNC_OR,  5'd19, 5'd31, 5'd3, 32'h0);
    send_op(FUNC_XOR, 5'd20, 5'd31, 5'd4, 32'h0);
    // source equals destination
    send_op(FUNC_ADD, 5'd31, 5'd31, 5'd31, 32'h0);
    send_op(FUNC_DIV, 5'd12, 5'd12, 5'd12, 32'h0);
    // divide error must leave r1 intact
    send_op(FUNC_DIV, 5'd1,  5'd2, 5'd0, 32'h0);
    send_op(FUNC_SUB, 5'd22, 5'd1, 5'd0, 32'h0);
    wait_drained();
  endtask

  // Bulk of the run: random instructions with random gaps on both sides
  task automatic test_random_mix();
    repeat (400) send_instr(random_instr());
    wait_drained();
  endtask

  // Stretch with no idling at all on either channel
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (30) send_instr(random_instr());
    wait_drained();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: ready drops for random stretches, never while calm
  // ---------------------------------------------------------------------------
  initial begin : result_ready_gen
    int unsigned hold_cnt;
    hold_cnt = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm) hold_cnt = 0;
      if (hold_cnt != 0) begin
        result_bus.ready <= 1'b0;
        hold_cnt--;
      end else begin
        result_bus.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold_cnt = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string field, word_t want, word_t got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_result
    result_t want;
    if (rst_ni === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual reg %0d value 0x%08h err %0b",
                 $time, result_bus.written_reg, result_bus.result_value,
                 result_bus.divide_error);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("written_reg",  word_t'(want.reg_idx), word_t'(result_bus.written_reg));
        compare_field("result_value", want.value,            word_t'(result_bus.result_value));
        compare_field("divide_error", word_t'(want.div_err), word_t'(result_bus.divide_error));
      end
    end
  end

  // Watchdog: ends the run if no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((instr_bus.valid && instr_bus.ready) || (result_bus.valid && result_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
             $time, WatchdogLimit, pending_results.size());
    $display("register_file_alu_execute regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_ni              = 1'b0;
    instr_bus.valid     = 1'b0;
    instr_bus.func      = FUNC_ADD;
    instr_bus.dest_reg  = '0;
    instr_bus.src_a_reg = '0;
    instr_bus.src_b_reg = '0;
    instr_bus.immediate = '0;
    foreach (reg_model[i]) reg_model[i] = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_mix();
    test_back_to_back();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("register_file_alu_execute regression: pass");
    end else begin
      $display("register_file_alu_execute regression: fail");
    end
    $finish;
  end

endmodule

FILE: register_file_alu_execute.f
hdl/rfae_pkg.sv
hdl/rfae_if.sv
hdl/rfae_ram.sv
hdl/rfae_div.sv
hdl/register_file_alu_execute.sv
test/tb.sv
